FILE: rtl/aae_pkg.sv
// aae_pkg: shared types and constants of the adaptive arithmetic encoder
// depends on nothing; used by aae_pack and adaptive_arith_encoder
package aae_pkg;

  localparam int CHUNK_W    = 32;  // bits in one output chunk
  localparam int FILL_W     = 6;   // width of the bit count field
  localparam int MAX_CHUNKS = 64;  // chunks one request may produce
  localparam int CHUNK_AW   = 6;   // address width of the chunk buffer
  localparam int NUM_W      = 7;   // chunk counter, holds MAX_CHUNKS itself
  localparam int OUT_DW     = 40;  // master tdata width, whole bytes

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  localparam logic REG_MAX_SYMBOL = 1'b0;

  typedef struct packed {
    logic bit_en;   // one code bit this cycle
    logic bit_val;
    logic finish;   // request done, play out chunks
    logic sat;      // pending count saturated during this request
    logic oos;      // symbol out of range
  } pack_ctl_t;

endpackage

FILE: rtl/aae_ram.sv
// aae_ram: generic single write port, single read port ram
// registered read; no dependencies
module aae_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 257
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/aae_div.sv
// aae_div: restoring divider, one quotient bit per cycle
// no dependencies; shared by both interval bound computations
module aae_div #(
  parameter int NW = 49,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CW = $clog2(NW + 1);

  logic [DW:0]   rem;
  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          run;
  logic [DW:0]   trial;

  assign trial = {rem[DW-1:0], quotient[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run      <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (run) begin
        if (trial >= {1'b0, dvs}) begin
          rem      <= trial - {1'b0, dvs};
          quotient <= {quotient[NW-2:0], 1'b1};
        end else begin
          rem      <= trial;
          quotient <= {quotient[NW-2:0], 1'b0};
        end
        if (cnt == CW'(NW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

FILE: rtl/aae_pack.sv
// aae_pack: packs code bits into 32-bit chunks, buffers them, plays them out
// depends on aae_pkg and aae_ram
module aae_pack (
  input  logic                       clk,
  input  logic                       rst,
  input  aae_pkg::pack_ctl_t         ctl,
  output logic                       busy,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [aae_pkg::OUT_DW-1:0] m_tdata,
  output logic                       m_tlast,
  output logic [1:0]                 m_tuser
);

  typedef enum logic [1:0] {P_COLLECT, P_RD, P_WAIT, P_OUT} p_state_t;

  p_state_t                       p_state;
  logic [aae_pkg::CHUNK_W-1:0]    acc;
  logic [aae_pkg::CHUNK_W-1:0]    acc_next;
  logic [aae_pkg::FILL_W-2:0]     fill;
  logic [aae_pkg::FILL_W-1:0]     last_fill;
  logic [aae_pkg::NUM_W-1:0]      num;
  logic [aae_pkg::NUM_W-1:0]      num_f;
  logic [aae_pkg::CHUNK_AW-1:0]   k;
  logic                           drop;
  logic [1:0]                     stat;
  logic [1:0]                     stat_f;
  logic                           room;
  logic                           partial;
  logic                           we;
  logic [aae_pkg::CHUNK_W-1:0]    wdata;
  logic [aae_pkg::CHUNK_W-1:0]    rdata;
  logic                           k_last;

  assign acc_next = {acc[aae_pkg::CHUNK_W-2:0], ctl.bit_val};
  assign room     = num < aae_pkg::NUM_W'(aae_pkg::MAX_CHUNKS);
  assign partial  = (fill != '0) && room;
  assign num_f    = num + aae_pkg::NUM_W'(partial);
  assign stat_f   = (drop || ctl.sat) ? aae_pkg::ST_SAT : aae_pkg::ST_OK;
  assign k_last   = (aae_pkg::NUM_W'(k) + 1'b1) == num;
  assign busy     = p_state != P_COLLECT;

  always_comb begin
    we    = 1'b0;
    wdata = acc_next;
    if (p_state == P_COLLECT) begin
      if (ctl.bit_en && room && (fill == '1)) begin
        we = 1'b1;
      end else if (ctl.finish && !ctl.oos && partial) begin
        we    = 1'b1;
        wdata = acc;
      end
    end
  end

  aae_ram #(
    .WIDTH(aae_pkg::CHUNK_W),
    .DEPTH(aae_pkg::MAX_CHUNKS)
  ) u_chunks (
    .clk  (clk),
    .we   (we),
    .waddr(num[aae_pkg::CHUNK_AW-1:0]),
    .wdata(wdata),
    .raddr(k),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p_state  <= P_COLLECT;
      acc      <= '0;
      fill     <= '0;
      num      <= '0;
      drop     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      case (p_state)
        P_COLLECT: begin
          if (ctl.bit_en) begin
            if (!room) begin
              drop <= 1'b1;
            end else if (fill == '1) begin
              num  <= num + 1'b1;
              acc  <= '0;
              fill <= '0;
            end else begin
              acc  <= acc_next;
              fill <= fill + 1'b1;
            end
          end else if (ctl.finish) begin
            if (ctl.oos) begin
              m_tdata  <= '0;
              m_tlast  <= 1'b1;
              m_tuser  <= aae_pkg::ST_RANGE;
              m_tvalid <= 1'b1;
              p_state  <= P_OUT;
            end else begin
              stat      <= stat_f;
              last_fill <= partial ? aae_pkg::FILL_W'(fill)
                                   : aae_pkg::FILL_W'(aae_pkg::CHUNK_W);
              num       <= num_f;
              k         <= '0;
              if (num_f != '0) begin
                p_state <= P_RD;
              end else if (stat_f != aae_pkg::ST_OK) begin
                // nothing coded but something to report
                m_tdata  <= '0;
                m_tlast  <= 1'b1;
                m_tuser  <= stat_f;
                m_tvalid <= 1'b1;
                p_state  <= P_OUT;
              end
            end
          end
        end
        P_RD: begin
          p_state <= P_WAIT;
        end
        P_WAIT: begin
          m_tdata  <= {{(aae_pkg::OUT_DW - aae_pkg::CHUNK_W - aae_pkg::FILL_W){1'b0}},
                       k_last ? last_fill : aae_pkg::FILL_W'(aae_pkg::CHUNK_W), rdata};
          m_tlast  <= k_last;
          m_tuser  <= stat;
          m_tvalid <= 1'b1;
          p_state  <= P_OUT;
        end
        P_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (m_tlast) begin
              acc     <= '0;
              fill    <= '0;
              num     <= '0;
              drop    <= 1'b0;
              p_state <= P_COLLECT;
            end else begin
              k       <= k + 1'b1;
              p_state <= P_RD;
            end
          end
        end
        default: p_state <= P_COLLECT;
      endcase
    end
  end

endmodule

FILE: rtl/adaptive_arith_encoder.sv
// adaptive_arith_encoder: top level, sequencer of the coder and model
// depends on aae_pkg, aae_ram, aae_div and aae_pack
//
// channel  dir  handshake                 payload
// s_*      in   s_tvalid/s_tready         tdata symbol, tuser req_type
// m_*      out  m_tvalid/m_tready         tdata code_bits/bit_count, tlast, tuser status
// apb      in   psel/penable/pwrite       register max_symbol at address 0
//
// an encode walks the count ram for the cumulative count, then runs two passes
// of the shared divider, then the renormalization steps and the code bits they
// emit. each chunk then plays out through the read, wait and output states,
// held there by any m_tready stall.
// reset, a flush and a max_symbol write run a clearing pass over the count
// ram; s_tready stays low during it and during playout.
module adaptive_arith_encoder #(
  parameter int ALPHABET_MAX = 256,
  parameter int CODE_BITS    = 32,
  parameter int MAX_TOTAL    = 65535,
  parameter int PENDING_MAX  = 1023
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // symbol[7:0]
  input  logic                       s_tuser,   // req_type
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [aae_pkg::OUT_DW-1:0] m_tdata,   // code_bits[31:0], bit_count[37:32], zero
  output logic                       m_tlast,
  output logic [1:0]                 m_tuser,   // status[1:0]
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam longint QUARTER = longint'(1) << (CODE_BITS - 2);
  localparam longint CAP     = (longint'(MAX_TOTAL) < QUARTER) ? longint'(MAX_TOTAL)
                                                               : QUARTER - 1;
  localparam int CW  = $clog2(CAP + 1);
  localparam int SW  = $clog2(ALPHABET_MAX + 1);
  localparam int PW  = CODE_BITS + 1 + CW;
  localparam int PNW = $clog2(PENDING_MAX + 1);
  localparam int ELW = $clog2(PENDING_MAX + 2);
  localparam int GW  = $clog2(2 * CODE_BITS + 3);
  localparam logic [CODE_BITS-1:0] HALF = CODE_BITS'(longint'(1) << (CODE_BITS - 1));
  localparam logic [CODE_BITS-1:0] QTR  = CODE_BITS'(QUARTER);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_CUMR, S_CUMW, S_MULH, S_STH, S_DIVH,
    S_MULL, S_STL, S_DIVL, S_UPD, S_REN, S_EMIT, S_FIN
  } state_t;

  state_t               state;
  logic [7:0]           max_symbol;
  logic [7:0]           top;
  logic [CODE_BITS-1:0] low;
  logic [CODE_BITS-1:0] high;
  logic [CODE_BITS-1:0] hnew;
  logic [PNW-1:0]       pending;
  logic [CW-1:0]        total;
  logic [CW-1:0]        cum;
  logic [CW-1:0]        cnt_sym;
  logic [SW-1:0]        idx;
  logic [SW-1:0]        sym;
  logic [GW-1:0]        guard;
  logic [ELW-1:0]       emit_left;
  logic                 emit_bit;
  logic                 emit_first;
  logic                 flushing;
  logic                 sat;
  logic [PW-1:0]        prod;
  logic [CODE_BITS:0]   range;
  logic [CW-1:0]        factor;
  logic                 cfg_wr;
  logic                 in_acc;
  logic                 pack_busy;
  aae_pkg::pack_ctl_t   pctl;
  logic                 cnt_we;
  logic [SW-1:0]        cnt_waddr;
  logic [CW-1:0]        cnt_wdata;
  logic [CW-1:0]        cnt_rdata;
  logic                 div_start;
  logic                 div_done;
  logic [PW-1:0]        quo;
  logic [CODE_BITS-1:0] low_sh;
  logic [CODE_BITS-1:0] high_sh;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == aae_pkg::REG_MAX_SYMBOL);
  assign prdata   = (paddr[2] == aae_pkg::REG_MAX_SYMBOL) ? {24'd0, max_symbol} : 32'd0;
  assign s_tready = (state == S_IDLE) && !pack_busy;
  assign in_acc   = s_tvalid && s_tready;

  // usable alphabet top
  always_comb begin
    top = max_symbol;
    if (32'(top) > 32'(ALPHABET_MAX - 1)) top = 8'(ALPHABET_MAX - 1);
    if (longint'(top) + 2 > CAP) top = 8'(CAP - 2);
  end

  assign range  = {1'b0, high} - {1'b0, low} + 1'b1;
  assign factor = (state == S_MULH) ? cum + cnt_sym : cum;

  // interval after the E2 or E3 subtraction and before the shift
  always_comb begin
    low_sh  = low;
    high_sh = high;
    if (high >= HALF && low >= HALF) begin
      low_sh  = low - HALF;
      high_sh = high - HALF;
    end else if (high >= HALF) begin
      low_sh  = low - QTR;
      high_sh = high - QTR;
    end
  end

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = idx;
    cnt_wdata = CW'(1);
    if (state == S_CLR) begin
      cnt_we = 1'b1;
    end else if (state == S_UPD && total < CW'(CAP)) begin
      cnt_we    = 1'b1;
      cnt_waddr = sym;
      cnt_wdata = cnt_sym + 1'b1;
    end
  end

  assign div_start = (state == S_STH) || (state == S_STL);

  always_comb begin
    pctl         = '0;
    pctl.bit_en  = (state == S_EMIT);
    pctl.bit_val = emit_first ? emit_bit : !emit_bit;
    pctl.finish  = (state == S_FIN) ||
                   (in_acc && !s_tuser && (s_tdata > top));
    pctl.sat     = sat;
    pctl.oos     = (state == S_IDLE);
  end

  aae_ram #(
    .WIDTH(CW),
    .DEPTH(ALPHABET_MAX + 1)
  ) u_counts (
    .clk  (clk),
    .we   (cnt_we),
    .waddr(cnt_waddr),
    .wdata(cnt_wdata),
    .raddr(idx),
    .rdata(cnt_rdata)
  );

  aae_div #(
    .NW(PW),
    .DW(CW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(prod),
    .divisor (total),
    .done    (div_done),
    .quotient(quo)
  );

  aae_pack u_pack (
    .clk     (clk),
    .rst     (rst),
    .ctl     (pctl),
    .busy    (pack_busy),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      if (rst) begin
        max_symbol <= 8'd255;
      end else begin
        max_symbol <= pwdata[7:0];
      end
      state    <= S_CLR;
      idx      <= '0;
      low      <= '0;
      high     <= '1;
      pending  <= '0;
      sat      <= 1'b0;
      flushing <= 1'b0;
    end else begin
      case (state)
        S_CLR: begin
          if (idx == SW'(ALPHABET_MAX)) begin
            total <= CW'(top) + CW'(2);
            state <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            sat <= 1'b0;
            if (s_tuser) begin
              emit_bit   <= low >= QTR;
              emit_left  <= ELW'(pending) + 1'b1;
              emit_first <= 1'b1;
              flushing   <= 1'b1;
              state      <= S_EMIT;
            end else if (s_tdata <= top) begin
              sym   <= SW'(s_tdata);
              idx   <= '0;
              cum   <= '0;
              state <= S_CUMR;
            end
          end
        end
        S_CUMR: begin
          state <= S_CUMW;
        end
        S_CUMW: begin
          if (idx == sym) begin
            cnt_sym <= cnt_rdata;
            state   <= S_MULH;
          end else begin
            cum   <= cum + cnt_rdata;
            idx   <= idx + 1'b1;
            state <= S_CUMR;
          end
        end
        S_MULH: begin
          prod  <= PW'(range) * PW'(factor);
          state <= S_STH;
        end
        S_STH: begin
          state <= S_DIVH;
        end
        S_DIVH: begin
          if (div_done) begin
            hnew  <= low + quo[CODE_BITS-1:0] - 1'b1;
            state <= S_MULL;
          end
        end
        S_MULL: begin
          prod  <= PW'(range) * PW'(factor);
          state <= S_STL;
        end
        S_STL: begin
          state <= S_DIVL;
        end
        S_DIVL: begin
          if (div_done) begin
            low   <= low + quo[CODE_BITS-1:0];
            high  <= hnew;
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (total < CW'(CAP)) begin
            total <= total + 1'b1;
          end
          guard <= '0;
          state <= S_REN;
        end
        S_REN: begin
          if (guard == GW'(2 * CODE_BITS + 2)) begin
            state <= S_FIN;
          end else if (high < HALF || low >= HALF ||
                       (low >= QTR && high < HALF + QTR)) begin
            guard <= guard + 1'b1;
            low   <= {low_sh[CODE_BITS-2:0], 1'b0};
            high  <= {high_sh[CODE_BITS-2:0], 1'b1};
            if (high < HALF || low >= HALF) begin
              // settled bit followed by the pending opposite bits
              emit_bit   <= low >= HALF;
              emit_left  <= ELW'(pending);
              emit_first <= 1'b1;
              pending    <= '0;
              state      <= S_EMIT;
            end else if (pending < PNW'(PENDING_MAX)) begin
              pending <= pending + 1'b1;
            end else begin
              sat <= 1'b1;
            end
          end else begin
            state <= S_FIN;
          end
        end
        S_EMIT: begin
          emit_first <= 1'b0;
          if (!emit_first) begin
            emit_left <= emit_left - 1'b1;
          end
          if ((emit_first && emit_left == '0) || (!emit_first && emit_left == ELW'(1))) begin
            state <= flushing ? S_FIN : S_REN;
          end
        end
        S_FIN: begin
          if (flushing) begin
            flushing <= 1'b0;
            idx      <= '0;
            low      <= '0;
            high     <= '1;
            pending  <= '0;
            state    <= S_CLR;
          end else begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLR;
      endcase
    end
  end

endmodule
